### sv/hpd_pkg.sv
// Shared types, constants and register codes for the heatmap peak detector.
`timescale 1ns / 1ps

package hpd_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int VALUE_BITS_DEF = 16;

    localparam int CFG_DATA_BITS  = 16;
    localparam int SIZE_BITS      = 9;
    localparam int THRESH_BITS    = 16;
    localparam int COORD_BITS     = 8;
    localparam int NUM_CASES      = 4;

    localparam logic [SIZE_BITS-1:0]   FRAME_WIDTH_RST  = 9'd64;
    localparam logic [SIZE_BITS-1:0]   FRAME_HEIGHT_RST = 9'd64;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RST    = 16'd0;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_PEAK_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]          frame_width;
        logic [SIZE_BITS-1:0]          frame_height;
        logic signed [THRESH_BITS-1:0] peak_threshold;
    } cfg_t;

    // Position and flags of one decided pixel
    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  is_peak;
        logic                  frame_end;
    } res_info_t;

    typedef struct packed {
        logic empty;
        logic single;
    } buf_status_t;

endpackage

### sv/hpd_line_buf.sv
// Two line stores with registered read and write-to-read bypass.
`timescale 1ns / 1ps

module hpd_line_buf
    import hpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
    input  logic signed [VALUE_BITS-1:0] wdata_older,
    input  logic signed [VALUE_BITS-1:0] wdata_newer,
    input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
    output logic signed [VALUE_BITS-1:0] rd_older,
    output logic signed [VALUE_BITS-1:0] rd_newer
);

    logic signed [VALUE_BITS-1:0] older_mem [MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] newer_mem [MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] rd_older_reg;
    logic signed [VALUE_BITS-1:0] rd_newer_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            older_mem[waddr] <= wdata_older;
            newer_mem[waddr] <= wdata_newer;
        end
    end

    // Forward the write when a one-column frame reads back the same entry
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rd_older_reg <= wdata_older;
            rd_newer_reg <= wdata_newer;
        end
        else
        begin
            rd_older_reg <= older_mem[raddr];
            rd_newer_reg <= newer_mem[raddr];
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;

endmodule

### sv/hpd_nms_core.sv
// Window registers, raster counters and the 3x3 local-maximum decisions.
`timescale 1ns / 1ps

module hpd_nms_core
    import hpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic signed [VALUE_BITS-1:0] logit,
    input  logic signed [VALUE_BITS-1:0] rd_older,
    input  logic signed [VALUE_BITS-1:0] rd_newer,
    input  cfg_t                         cfg,
    output logic [$clog2(MAX_WIDTH)-1:0] col_cur,
    output logic [$clog2(MAX_WIDTH)-1:0] col_next,
    output logic [NUM_CASES-1:0]         res_mask,
    output res_info_t                    res_info  [NUM_CASES],
    output logic signed [VALUE_BITS-1:0] res_value [NUM_CASES]
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WSZ  = (CW + 1 > SIZE_BITS) ? CW + 1 : SIZE_BITS;
    localparam int HSZ  = (RW + 1 > SIZE_BITS) ? RW + 1 : SIZE_BITS;
    localparam int CMPW = (VALUE_BITS > THRESH_BITS) ? VALUE_BITS : THRESH_BITS;

    logic [CW-1:0]                col_count_reg;
    logic [RW-1:0]                row_count_reg;
    logic [RW-1:0]                row_count_next;
    logic signed [VALUE_BITS-1:0] win_reg [6];

    logic [WSZ-1:0]               fw_ext;
    logic [HSZ-1:0]               fh_ext;
    logic [CW-1:0]                last_col;
    logic [RW-1:0]                last_row_idx;
    logic                         row_end;
    logic                         last_row;
    logic                         row_ge1;
    logic                         row_ge2;
    logic                         col_ge1;
    logic                         col_ge2;

    logic signed [VALUE_BITS-1:0] grid [4][4];
    logic                         rv   [4];
    logic                         cv   [4];
    logic signed [CMPW-1:0]       thr_ext;
    logic signed [CMPW-1:0]       ctr_ext [NUM_CASES];
    logic [NUM_CASES-1:0]         peak;

    // Clamp the programmed sizes to 1..MAX and take the last index
    always_comb
    begin
        fw_ext = WSZ'(cfg.frame_width);
        fh_ext = HSZ'(cfg.frame_height);
        if (cfg.frame_width == '0)
            last_col = '0;
        else if (fw_ext > WSZ'(MAX_WIDTH))
            last_col = CW'(MAX_WIDTH - 1);
        else
            last_col = CW'(fw_ext - 1'b1);
        if (cfg.frame_height == '0)
            last_row_idx = '0;
        else if (fh_ext > HSZ'(MAX_HEIGHT))
            last_row_idx = RW'(MAX_HEIGHT - 1);
        else
            last_row_idx = RW'(fh_ext - 1'b1);
    end

    assign row_end  = col_count_reg >= last_col;
    assign last_row = row_count_reg >= last_row_idx;
    assign row_ge1  = row_count_reg != '0;
    assign row_ge2  = row_count_reg > RW'(1);
    assign col_ge1  = col_count_reg != '0;
    assign col_ge2  = col_count_reg > CW'(1);

    // Grid rows: top, mid, bottom, none; columns: left, mid, right, none
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                grid[i][j] = '0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            grid[i][0] = win_reg[i];
            grid[i][1] = win_reg[3 + i];
        end
        grid[0][2] = rd_older;
        grid[1][2] = rd_newer;
        grid[2][2] = logit;
        rv[0] = row_ge2;
        rv[1] = row_ge1;
        rv[2] = 1'b1;
        rv[3] = 1'b0;
        cv[0] = col_ge2;
        cv[1] = col_ge1;
        cv[2] = 1'b1;
        cv[3] = 1'b0;
    end

    assign thr_ext = cfg.peak_threshold;

    // Case k: row offset k[1], column offset k[0] of the decided window
    always_comb
    begin
        for (int k = 0; k < NUM_CASES; k++)
        begin
            res_value[k] = grid[(k >> 1) + 1][(k & 1) + 1];
            ctr_ext[k]   = res_value[k];
            peak[k]      = ctr_ext[k] >= thr_ext;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (rv[(k >> 1) + i] && cv[(k & 1) + j]
                        && (grid[(k >> 1) + i][(k & 1) + j] > res_value[k]))
                        peak[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        res_mask[0] = row_ge1 && col_ge1;
        res_mask[1] = row_ge1 && row_end;
        res_mask[2] = last_row && col_ge1;
        res_mask[3] = last_row && row_end;

        res_info[0].col = COORD_BITS'(col_count_reg - 1'b1);
        res_info[0].row = COORD_BITS'(row_count_reg - 1'b1);
        res_info[1].col = COORD_BITS'(col_count_reg);
        res_info[1].row = COORD_BITS'(row_count_reg - 1'b1);
        res_info[2].col = COORD_BITS'(col_count_reg - 1'b1);
        res_info[2].row = COORD_BITS'(row_count_reg);
        res_info[3].col = COORD_BITS'(col_count_reg);
        res_info[3].row = COORD_BITS'(row_count_reg);
        for (int k = 0; k < NUM_CASES; k++)
        begin
            res_info[k].is_peak   = peak[k];
            res_info[k].frame_end = (k == NUM_CASES - 1);
        end
    end

    // Advance the raster position on each transfer
    always_comb
    begin
        col_next       = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next       = '0;
                row_count_next = last_row ? '0 : RW'(row_count_reg + 1'b1);
            end
            else
            begin
                col_next = CW'(col_count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            col_count_reg <= col_next;
            row_count_reg <= row_count_next;
            if (accept)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i]     <= grid[i][1];
                    win_reg[3 + i] <= grid[i][2];
                end
            end
        end
    end

    assign col_cur = col_count_reg;

endmodule

### sv/hpd_result_buf.sv
// Four-entry result register, drained one result per output transfer.
`timescale 1ns / 1ps

module hpd_result_buf
    import hpd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [NUM_CASES-1:0]         res_mask,
    input  res_info_t                    res_info  [NUM_CASES],
    input  logic signed [VALUE_BITS-1:0] res_value [NUM_CASES],
    output buf_status_t                  status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS-1:0]        col,
    output logic [COORD_BITS-1:0]        row,
    output logic signed [VALUE_BITS-1:0] value,
    output logic                         is_peak,
    output logic                         frame_end
);

    logic [NUM_CASES-1:0]         mask_reg;
    logic [NUM_CASES-1:0]         mask_next;
    res_info_t                    info_reg  [NUM_CASES];
    logic signed [VALUE_BITS-1:0] value_reg [NUM_CASES];
    logic [$clog2(NUM_CASES)-1:0] sel;
    logic                         fire;

    // Present the lowest pending entry, which keeps raster order
    always_comb
    begin
        sel = '0;
        for (int k = NUM_CASES - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
                sel = ($clog2(NUM_CASES))'(k);
        end
    end

    assign out_valid     = mask_reg != '0;
    assign fire          = out_valid && !out_stall;
    assign status.empty  = mask_reg == '0;
    assign status.single = $onehot(mask_reg);

    assign col       = info_reg[sel].col;
    assign row       = info_reg[sel].row;
    assign is_peak   = info_reg[sel].is_peak;
    assign frame_end = info_reg[sel].frame_end;
    assign value     = value_reg[sel];

    always_comb
    begin
        mask_next = mask_reg;
        if (fire)
            mask_next[sel] = 1'b0;
        if (load)
            mask_next = res_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NUM_CASES; k++)
            begin
                info_reg[k]  <= res_info[k];
                value_reg[k] <= res_value[k];
            end
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (mask_reg == '0 || ($onehot(mask_reg) && fire)))
        else $error("results loaded over pending entries");

    a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !load) |=> ($countones(mask_reg) + 1 == $countones($past(mask_reg))))
        else $error("output transfer did not retire exactly one entry");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (!fire && !load) |=> (mask_reg == $past(mask_reg)))
        else $error("pending entries changed without a transfer");

    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg[NUM_CASES-1] |-> info_reg[NUM_CASES-1].frame_end)
        else $error("final-pixel entry lost its frame end flag");

endmodule

### sv/heatmap_peak_detector_unit.sv
// Top level of the streaming 3x3 heatmap peak detector.
`timescale 1ns / 1ps

// Logits enter in raster order and each pixel is reported once its 3x3
// window, clamped at the frame edges, is complete: pixel (r,c) comes out when
// (r+1,c+1) is taken, or earlier on the right column and bottom row. A pixel
// is a peak when no in-frame neighbor is strictly larger and its logit is at
// least peak_threshold. Pixels are taken one per cycle while not stalled; a
// pixel's decisions land in a four-entry result register and leave one per
// cycle while out_stall is low, so the input is held while results are
// pending unless the last of them leaves now: up to two results
// per pixel at row ends and on the last row, four for the final pixel of a
// frame. Line stores read one column ahead, so no clearing pass follows
// reset. Write the size and threshold registers only while the block is idle.
module heatmap_peak_detector_unit
    import hpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] logit,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS-1:0]        col,
    output logic [COORD_BITS-1:0]        row,
    output logic signed [VALUE_BITS-1:0] value,
    output logic                         is_peak,
    output logic                         frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_t                         cfg_reg;
    buf_status_t                  buf_status;
    logic                         accept;
    logic                         out_fire;
    logic [CW-1:0]                col_cur;
    logic [CW-1:0]                col_next;
    logic signed [VALUE_BITS-1:0] rd_older;
    logic signed [VALUE_BITS-1:0] rd_newer;
    logic [NUM_CASES-1:0]         res_mask;
    res_info_t                    res_info  [NUM_CASES];
    logic signed [VALUE_BITS-1:0] res_value [NUM_CASES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= FRAME_WIDTH_RST;
            cfg_reg.frame_height   <= FRAME_HEIGHT_RST;
            cfg_reg.peak_threshold <= THRESH_BITS'(THRESHOLD_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:    cfg_reg.frame_width    <= cfg_data[SIZE_BITS-1:0];
                CFG_FRAME_HEIGHT:   cfg_reg.frame_height   <= cfg_data[SIZE_BITS-1:0];
                CFG_PEAK_THRESHOLD: cfg_reg.peak_threshold <= cfg_data[THRESH_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Take a pixel when the result register is empty or its last entry leaves now
    assign out_fire = out_valid && !out_stall;
    assign in_stall = !(buf_status.empty || (buf_status.single && out_fire));
    assign accept   = in_valid && !in_stall;

    hpd_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_line_buf (
        .clk         (clk),
        .we          (accept),
        .waddr       (col_cur),
        .wdata_older (rd_newer),
        .wdata_newer (logit),
        .raddr       (col_next),
        .rd_older    (rd_older),
        .rd_newer    (rd_newer)
    );

    hpd_nms_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VALUE_BITS (VALUE_BITS)
    ) u_nms_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .logit     (logit),
        .rd_older  (rd_older),
        .rd_newer  (rd_newer),
        .cfg       (cfg_reg),
        .col_cur   (col_cur),
        .col_next  (col_next),
        .res_mask  (res_mask),
        .res_info  (res_info),
        .res_value (res_value)
    );

    hpd_result_buf #(
        .VALUE_BITS (VALUE_BITS)
    ) u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_mask  (res_mask),
        .res_info  (res_info),
        .res_value (res_value),
        .status    (buf_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col       (col),
        .row       (row),
        .value     (value),
        .is_peak   (is_peak),
        .frame_end (frame_end)
    );

endmodule

### dv/tb.sv
// Self-checking testbench for the streaming 3x3 heatmap peak detector.
`timescale 1ns / 1ps

module tb;
    import hpd_pkg::*;

    localparam int MAX_SIDE       = 256;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int HOLD_OFF       = 100;
    localparam int RANDOM_ITEMS   = 180;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] value;
        logic               is_peak;
        logic               frame_end;
    } pixel_result_t;

    // One row of the opening sequence: a register write or a pixel
    typedef struct packed {
        logic               is_cfg;
        cfg_index_t         idx;
        logic [15:0]        data;
        logic signed [15:0] px;
        logic               typed;
        logic               peak;
    } opening_step_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] logit = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [15:0] value;
    logic               is_peak;
    logic               frame_end;

    // Predictor copy of the block state
    logic signed [15:0] older_line_m [MAX_SIDE];
    logic signed [15:0] newer_line_m [MAX_SIDE];
    logic signed [15:0] window_m [6];
    int unsigned        col_m;
    int unsigned        row_m;
    logic [8:0]         width_m;
    logic [8:0]         height_m;
    logic signed [15:0] thresh_m;
    logic signed [15:0] grid [4][4];
    bit                 row_ok [4];
    bit                 col_ok [4];

    pixel_result_t      fresh_results [$];
    pixel_result_t      pending_results [$];
    opening_step_t      opening_steps [$];
    pixel_result_t      head;
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    bit                 no_gaps = 1'b0;
    bit                 squeeze_go = 1'b0;
    bit                 squeeze_done = 1'b0;

    heatmap_peak_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .logit     (logit),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col       (col),
        .row       (row),
        .value     (value),
        .is_peak   (is_peak),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_size(input logic [8:0] size_reg);
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_SIDE)
            return MAX_SIDE;
        return size_reg;
    endfunction

    // Decide the pixel whose window is centered at grid row rb+1, column cb+1
    task automatic rate_window(input int rb, input int cb, input int unsigned r,
                               input int unsigned c, input bit last);
        logic signed [15:0] center;
        pixel_result_t      res;
        bit                 peak;
        center = grid[rb + 1][cb + 1];
        peak = (center >= thresh_m);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (row_ok[rb + i] && col_ok[cb + j] && grid[rb + i][cb + j] > center)
                    peak = 1'b0;
        res.col = c[7:0];
        res.row = r[7:0];
        res.value = center;
        res.is_peak = peak;
        res.frame_end = last;
        fresh_results.push_back(res);
    endtask

    task automatic judge_pixel(input logic signed [15:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ci;
        bit          row_end;
        bit          last_row;
        w = clamp_size(width_m);
        h = clamp_size(height_m);
        c = col_m;
        r = row_m;
        ci = (c < MAX_SIDE) ? c : MAX_SIDE - 1;
        row_end = (c >= w - 1);
        last_row = (r >= h - 1);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                grid[i][j] = '0;
        for (int i = 0; i < 3; i++)
        begin
            grid[i][0] = window_m[i];
            grid[i][1] = window_m[3 + i];
        end
        grid[0][2] = older_line_m[ci];
        grid[1][2] = newer_line_m[ci];
        grid[2][2] = px;
        row_ok[0] = (r >= 2);
        row_ok[1] = (r >= 1);
        row_ok[2] = 1'b1;
        row_ok[3] = 1'b0;
        col_ok[0] = (c >= 2);
        col_ok[1] = (c >= 1);
        col_ok[2] = 1'b1;
        col_ok[3] = 1'b0;

        fresh_results.delete();
        if (r >= 1 && c >= 1)
            rate_window(0, 0, r - 1, c - 1, 1'b0);
        if (r >= 1 && row_end)
            rate_window(0, 1, r - 1, c, 1'b0);
        if (last_row && c >= 1)
            rate_window(1, 0, r, c - 1, 1'b0);
        if (last_row && row_end)
            rate_window(1, 1, r, c, 1'b1);

        // Shift the window and write the column back into the line stores
        older_line_m[ci] = grid[1][2];
        newer_line_m[ci] = grid[2][2];
        for (int i = 0; i < 3; i++)
        begin
            window_m[i] = grid[i][1];
            window_m[3 + i] = grid[i][2];
        end
        if (row_end)
        begin
            col_m = 0;
            row_m = last_row ? 0 : r + 1;
        end
        else
        begin
            col_m = c + 1;
        end
    endtask

    function automatic int pick_gap();
        int draw;
        draw = $urandom_range(0, 9);
        if (draw < 6)
            return 0;
        if (draw < 9)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic logic signed [15:0] pick_logit();
        int draw;
        int v;
        draw = $urandom_range(0, 9);
        if (draw < 6)
        begin
            v = $urandom_range(0, 6);
            v = v - 3;
        end
        else if (draw < 8)
            v = $urandom;
        else if (draw == 8)
            v = $urandom_range(0, 1) ? 32767 : -32768;
        else
        begin
            v = $urandom_range(0, 80);
            v = v - 40;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_size();
        int draw;
        draw = $urandom_range(0, 9);
        if (draw == 0)
            return 16'd0;
        if (draw == 1)
            return 16'd1;
        if (draw < 7)
            return 16'($urandom_range(2, 5));
        if (draw < 9)
            return 16'($urandom_range(6, 10));
        return 16'd3;
    endfunction

    function automatic logic [15:0] pick_threshold();
        int draw;
        int v;
        draw = $urandom_range(0, 5);
        if (draw == 0)
            return 16'h8000;
        if (draw == 1)
            return 16'h7FFF;
        if (draw == 2)
            return 16'($urandom);
        v = $urandom_range(0, 8);
        v = v - 4;
        return v[15:0];
    endfunction

    // Drop valid, drain every expected result, then let the pipeline empty
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:    width_m = data[8:0];
            CFG_FRAME_HEIGHT:   height_m = data[8:0];
            CFG_PEAK_THRESHOLD: thresh_m = data;
            default:            ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic signed [15:0] px, input bit typed,
                              input bit want_peak);
        int            gap;
        pixel_result_t want;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        logit <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        judge_pixel(px);
        if (typed)
        begin
            // Single-pixel frame: the pixel is its own window and ends the frame
            want.col = '0;
            want.row = '0;
            want.value = px;
            want.is_peak = want_peak;
            want.frame_end = 1'b1;
            pending_results.push_back(want);
        end
        else
        begin
            foreach (fresh_results[k])
                pending_results.push_back(fresh_results[k]);
        end
    endtask

    task automatic add_cfg(input cfg_index_t idx, input logic [15:0] data);
        opening_step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        opening_steps.push_back(s);
    endtask

    task automatic add_px(input logic signed [15:0] px, input bit typed, input bit peak);
        opening_step_t s;
        s = '0;
        s.px = px;
        s.typed = typed;
        s.peak = peak;
        opening_steps.push_back(s);
    endtask

    // Stimulus
    initial
    begin
        int random_taken;
        int unsigned w;
        int unsigned h;
        int burst;
        random_taken = 0;
        for (int i = 0; i < MAX_SIDE; i++)
        begin
            older_line_m[i] = '0;
            newer_line_m[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            window_m[i] = '0;
        col_m = 0;
        row_m = 0;
        width_m = FRAME_WIDTH_RST;
        height_m = FRAME_HEIGHT_RST;
        thresh_m = THRESHOLD_RST;

        // Single-pixel frames at the threshold extremes
        add_cfg(CFG_FRAME_WIDTH, 16'd1);
        add_cfg(CFG_FRAME_HEIGHT, 16'd1);
        add_cfg(CFG_PEAK_THRESHOLD, 16'h8000);
        add_px(16'sh7FFF, 1'b1, 1'b1);
        add_px(16'sh8000, 1'b1, 1'b1);
        add_px(16'sh0000, 1'b1, 1'b1);
        add_cfg(CFG_PEAK_THRESHOLD, 16'h7FFF);
        add_px(16'sh7FFF, 1'b1, 1'b1);
        add_px(16'sh7FFE, 1'b1, 1'b0);
        // Zero sizes act as one
        add_cfg(CFG_FRAME_WIDTH, 16'd0);
        add_cfg(CFG_FRAME_HEIGHT, 16'd0);
        add_cfg(CFG_PEAK_THRESHOLD, 16'h0000);
        add_px(16'sh0000, 1'b1, 1'b1);
        add_px(16'shFFFF, 1'b1, 1'b0);
        add_px(16'sh0001, 1'b1, 1'b1);
        // 3x3 frame with ties and values below threshold
        add_cfg(CFG_FRAME_WIDTH, 16'd3);
        add_cfg(CFG_FRAME_HEIGHT, 16'd3);
        add_px(16'sd5, 1'b0, 1'b0);
        add_px(16'sd5, 1'b0, 1'b0);
        add_px(16'sd1, 1'b0, 1'b0);
        add_px(16'sd2, 1'b0, 1'b0);
        add_px(16'sd3, 1'b0, 1'b0);
        add_px(16'sd1, 1'b0, 1'b0);
        add_px(-16'sd2, 1'b0, 1'b0);
        add_px(16'sd9, 1'b0, 1'b0);
        add_px(16'sd9, 1'b0, 1'b0);
        // Shrink the width mid-frame with the column counter past the new end
        add_cfg(CFG_FRAME_WIDTH, 16'd4);
        add_cfg(CFG_FRAME_HEIGHT, 16'd4);
        for (int i = 0; i < 6; i++)
            add_px((i % 2) ? -16'sd7 : 16'sd7, 1'b0, 1'b0);
        add_cfg(CFG_FRAME_WIDTH, 16'd2);
        add_px(16'sd4, 1'b0, 1'b0);
        add_px(16'sd4, 1'b0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_steps[k])
        begin
            if (opening_steps[k].is_cfg)
                write_reg(opening_steps[k].idx, opening_steps[k].data);
            else
                send_pixel(opening_steps[k].px, opening_steps[k].typed,
                           opening_steps[k].peak);
        end

        // Random frames; some bursts stop mid-frame before the sizes change
        while (random_taken < RANDOM_ITEMS)
        begin
            write_reg(CFG_FRAME_WIDTH, pick_size());
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_FRAME_HEIGHT, pick_size());
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_PEAK_THRESHOLD, pick_threshold());
            w = clamp_size(width_m);
            h = clamp_size(height_m);
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(1, w * h);
            else
                burst = w * h * $urandom_range(1, 2);
            for (int i = 0; i < burst; i++)
                send_pixel(pick_logit(), 1'b0, 1'b0);
            random_taken += burst;
        end

        // Widest row, width saturated; the receiver holds off during it
        write_reg(CFG_FRAME_WIDTH, 16'h01FF);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        write_reg(CFG_PEAK_THRESHOLD, pick_threshold());
        no_gaps = 1'b1;
        squeeze_go = 1'b1;
        for (int i = 0; i < MAX_SIDE; i++)
            send_pixel(pick_logit(), 1'b0, 1'b0);
        no_gaps = 1'b0;

        // Tallest column, height saturated from an oversized write
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        for (int i = 0; i < MAX_SIDE; i++)
            send_pixel(pick_logit(), 1'b0, 1'b0);

        settle_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver stall pattern, with one long hold-off while the sender keeps going
    initial
    begin
        int draw;
        int run;
        repeat (3) @(posedge clk);
        forever
        begin
            if (squeeze_go && !squeeze_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                draw = $urandom_range(0, 9);
                if (draw < 6)
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(1, 20);
                end
                else if (draw < 9)
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(8, 30);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: col %0d row %0d value %0d peak %0b end %0b",
                             col, row, value, is_peak, frame_end);
            end
            else
            begin
                head = pending_results.pop_front();
                if (col !== head.col || row !== head.row || value !== head.value ||
                    is_peak !== head.is_peak || frame_end !== head.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"result mismatch: expected col %0d row %0d value %0d ",
                                  "peak %0b end %0b, got col %0d row %0d value %0d ",
                                  "peak %0b end %0b"},
                                 head.col, head.row, head.value, head.is_peak,
                                 head.frame_end, col, row, value, is_peak, frame_end);
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

### sim.f
sv/hpd_pkg.sv
sv/hpd_line_buf.sv
sv/hpd_nms_core.sv
sv/hpd_result_buf.sv
sv/heatmap_peak_detector_unit.sv
dv/tb.sv
